// ===== rtl/rpr_pkg.sv =====
`timescale 1ns / 1ps

package rpr_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned IDX_W  = 5;

  localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h20;
  localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h40;

  localparam logic [POS_W-1:0] SUM_FIRST_POS  = 5'd1;
  localparam logic [POS_W-1:0] SUM_LAST_POS   = 5'd29;
  localparam logic [POS_W-1:0] CHAN_FIRST_POS = 5'd2;
  localparam logic [POS_W-1:0] CHAN_LAST_POS  = 5'd21;
  localparam logic [POS_W-1:0] CHECK_POS      = 5'd30;
  localparam logic [POS_W-1:0] POS_MAX        = 5'd31;

  typedef struct packed {
    logic              channel_valid;
    logic [IDX_W-1:0]  channel_index;
    logic [BYTE_W-1:0] channel_byte;
    logic              packet_done;
    logic              checksum_ok;
  } rpr_result_t;

endpackage

// ===== rtl/rpr_rx_if.sv =====
`timescale 1ns / 1ps

interface rpr_rx_if
  import rpr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/rpr_cfg_if.sv =====
`timescale 1ns / 1ps

interface rpr_cfg_if
  import rpr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] checksum_start;

  modport source (output valid, output checksum_start, input ready);
  modport sink (input valid, input checksum_start, output ready);
endinterface

// ===== rtl/rpr_res_if.sv =====
`timescale 1ns / 1ps

interface rpr_res_if
  import rpr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              channel_valid;
  logic [IDX_W-1:0]  channel_index;
  logic [BYTE_W-1:0] channel_byte;
  logic              packet_done;
  logic              checksum_ok;

  modport source (
    output valid, output channel_valid, output channel_index, output channel_byte,
    output packet_done, output checksum_ok, input ready
  );
  modport sink (
    input valid, input channel_valid, input channel_index, input channel_byte,
    input packet_done, input checksum_ok, output ready
  );
endinterface

// ===== rtl/radio_packet_receiver.sv =====
`timescale 1ns / 1ps

// radio packet receiver: byte-serial parser for a 30-byte servo-radio packet
// rx: one received byte per transaction; a 0x20,0x40 pair starts a packet
// result: exactly one transaction per received byte, carrying channel byte
//   flags and index for positions 2 to 21, and packet done plus checksum
//   match for the byte at position 30
// cfg: write-only checksum start value, always ready; write only while idle
// path: an accepted byte is held in the input register, then in the result register
// throughput: one byte per cycle while result is taken, set by the single
//   parser stage between the input register and the result register
// stalls: when result is not taken the result register holds, the input
//   register holds its byte and rx.ready drops once both are full
// reset: position, checksum, last byte, checksum start and both valid
//   flags clear; bytes before a header count from position 1

module radio_packet_receiver
  import rpr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  rpr_rx_if.sink    rx,
  rpr_cfg_if.sink   cfg,
  rpr_res_if.source result
);

  logic [BYTE_W-1:0] checksum_start;
  logic              adv;
  logic              res_valid;
  rpr_result_t       res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      checksum_start <= '0;
    end else if (cfg.valid) begin
      checksum_start <= cfg.checksum_start;
    end
  end

  rpr_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .rx             (rx),
    .checksum_start (checksum_start),
    .adv            (adv),
    .res_valid      (res_valid),
    .res            (res)
  );

  rpr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .adv       (adv),
    .result    (result)
  );

endmodule

// ===== rtl/rpr_parser.sv =====
`timescale 1ns / 1ps

module rpr_parser
  import rpr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  rpr_rx_if.sink            rx,
  input  logic [BYTE_W-1:0] checksum_start,
  input  logic              adv,
  output logic              res_valid,
  output rpr_result_t       res
);

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic [BYTE_W-1:0] last_byte;
  logic [POS_W-1:0]  position;
  logic [BYTE_W-1:0] running_sum;

  logic              fire;
  logic              hdr;
  logic [POS_W-1:0]  position_next;
  logic [BYTE_W-1:0] sum_base;
  logic [BYTE_W-1:0] running_sum_next;
  logic              in_sum;
  logic              in_chan;
  logic              at_check;

  assign fire     = in_valid && adv;
  assign rx.ready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
    if (rx.ready && rx.valid) begin
      in_byte <= rx.rx_byte;
    end
  end

  always_comb begin
    hdr = (last_byte == HDR_FIRST) && (in_byte == HDR_SECOND);
    if (hdr) begin
      position_next = SUM_FIRST_POS;
      sum_base      = checksum_start;
    end else begin
      position_next = (position != POS_MAX) ? position + POS_W'(1) : position;
      sum_base      = running_sum;
    end
    in_sum   = (position_next >= SUM_FIRST_POS) && (position_next <= SUM_LAST_POS);
    in_chan  = (position_next >= CHAN_FIRST_POS) && (position_next <= CHAN_LAST_POS);
    at_check = (position_next == CHECK_POS);
    running_sum_next = in_sum ? sum_base - in_byte : sum_base;

    res.channel_valid = in_chan;
    res.channel_index = in_chan ? IDX_W'(position_next - CHAN_FIRST_POS) : '0;
    res.channel_byte  = in_chan ? in_byte : '0;
    res.packet_done   = at_check;
    res.checksum_ok   = at_check && (running_sum_next == in_byte);
  end

  assign res_valid = fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_byte   <= '0;
      position    <= '0;
      running_sum <= '0;
    end else if (fire) begin
      last_byte   <= in_byte;
      position    <= position_next;
      running_sum <= running_sum_next;
    end
  end

  a_hdr_restart: assert property (@(posedge clk) disable iff (rst)
    fire && last_byte == HDR_FIRST && in_byte == HDR_SECOND |=> position == SUM_FIRST_POS)
    else $error("header did not restart the packet");

  a_pos_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(position) && $stable(running_sum) && $stable(last_byte))
    else $error("parser state moved without a transaction");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    fire && position == POS_MAX && !hdr |=> position == POS_MAX)
    else $error("position left saturation without a header");

  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.channel_valid && res.packet_done) &&
                  (res.packet_done || !res.checksum_ok))
    else $error("inconsistent result flags");

endmodule

// ===== rtl/rpr_out_reg.sv =====
`timescale 1ns / 1ps

module rpr_out_reg
  import rpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        res_valid,
  input  rpr_result_t res,
  output logic        adv,
  rpr_res_if.source   result
);

  rpr_result_t data;

  assign adv = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= res_valid;
    end
    if (adv && res_valid) begin
      data <= res;
    end
  end

  assign result.channel_valid = data.channel_valid;
  assign result.channel_index = data.channel_index;
  assign result.channel_byte  = data.channel_byte;
  assign result.packet_done   = data.packet_done;
  assign result.checksum_ok   = data.checksum_ok;

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid && $stable(data))
    else $error("stalled result was lost or changed");

  a_no_load_on_stall: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !adv)
    else $error("result register advanced while stalled");

  a_load: assert property (@(posedge clk) disable iff (rst)
    adv && res_valid |=> result.valid)
    else $error("computed result not registered");

endmodule
